/* hdl/sst_pkg.sv */
// Package for the script source tokenizer: token kinds, error codes, field widths,
// keyword tables and character class helpers. No dependencies.
`default_nettype none
package sst_pkg;
  localparam int PositionBitsDefault = 20;
  localparam int LineBitsDefault = 16;
  localparam int KindBits = 6;
  localparam int ErrBits = 3;
  localparam int OutPosBits = 20;
  localparam int OutLineBits = 16;
  localparam int KwCount = 13;

  localparam logic [KindBits-1:0] K_IDENT = 6'd13;
  localparam logic [KindBits-1:0] K_NUMBER = 6'd14;
  localparam logic [KindBits-1:0] K_STRING = 6'd15;
  localparam logic [KindBits-1:0] K_PLUS = 6'd16;
  localparam logic [KindBits-1:0] K_STAR = 6'd17;
  localparam logic [KindBits-1:0] K_SLASH = 6'd18;
  localparam logic [KindBits-1:0] K_PERCENT = 6'd19;
  localparam logic [KindBits-1:0] K_LPAREN = 6'd20;
  localparam logic [KindBits-1:0] K_RPAREN = 6'd21;
  localparam logic [KindBits-1:0] K_LBRACE = 6'd22;
  localparam logic [KindBits-1:0] K_RBRACE = 6'd23;
  localparam logic [KindBits-1:0] K_LBRACK = 6'd24;
  localparam logic [KindBits-1:0] K_RBRACK = 6'd25;
  localparam logic [KindBits-1:0] K_COMMA = 6'd26;
  localparam logic [KindBits-1:0] K_DOT = 6'd27;
  localparam logic [KindBits-1:0] K_MINUS = 6'd28;
  localparam logic [KindBits-1:0] K_ARROW = 6'd29;
  localparam logic [KindBits-1:0] K_ASSIGN = 6'd30;
  localparam logic [KindBits-1:0] K_EQ = 6'd31;
  localparam logic [KindBits-1:0] K_BANG = 6'd32;
  localparam logic [KindBits-1:0] K_NE = 6'd33;
  localparam logic [KindBits-1:0] K_LT = 6'd34;
  localparam logic [KindBits-1:0] K_LE = 6'd35;
  localparam logic [KindBits-1:0] K_GT = 6'd36;
  localparam logic [KindBits-1:0] K_GE = 6'd37;
  localparam logic [KindBits-1:0] K_AND = 6'd38;
  localparam logic [KindBits-1:0] K_OR = 6'd39;
  localparam logic [KindBits-1:0] K_END = 6'd40;

  localparam logic [ErrBits-1:0] E_NONE = 3'd0;
  localparam logic [ErrBits-1:0] E_UNKNOWN = 3'd1;
  localparam logic [ErrBits-1:0] E_AMP = 3'd2;
  localparam logic [ErrBits-1:0] E_BAR = 3'd3;
  localparam logic [ErrBits-1:0] E_STRING = 3'd4;

  localparam logic [KwCount-1:0] KW_ALL = '1;

  // Keyword text, 6 bytes each, byte 0 in the low bits.
  localparam logic [47:0] KW_TEXT [KwCount] = '{
    48'h00_00_00_6E_75_66,  // fun
    48'h6E_72_75_74_65_72,  // return
    48'h00_00_00_00_66_69,  // if
    48'h66_69_65_73_6C_65,  // elseif
    48'h00_00_65_73_6C_65,  // else
    48'h00_65_6C_69_68_77,  // while
    48'h00_00_00_72_6F_66,  // for
    48'h00_6B_61_65_72_62,  // break
    48'h00_00_70_69_6B_73,  // skip
    48'h00_00_65_75_72_74,  // true
    48'h00_65_73_6C_61_66,  // false
    48'h00_00_6C_6C_75_6E,  // null
    48'h00_74_6E_69_72_70   // print
  };
  localparam logic [2:0] KW_LEN [KwCount] = '{3'd3, 3'd6, 3'd2, 3'd6, 3'd4, 3'd5, 3'd3,
                                               3'd5, 3'd4, 3'd4, 3'd5, 3'd4, 3'd5};

  // Scanner states
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_PEND    = 8'b0000_0010,
    S_COMMENT = 8'b0000_0100,
    S_INT     = 8'b0000_1000,
    S_DOTWAIT = 8'b0001_0000,
    S_FRAC    = 8'b0010_0000,
    S_STRING  = 8'b0100_0000,
    S_WORD    = 8'b1000_0000
  } scan_state_t;

  typedef struct packed {
    logic [KindBits-1:0]   kind;
    logic [OutPosBits-1:0] start;
    logic [OutPosBits-1:0] len;
    logic [OutLineBits-1:0] line;
    logic [ErrBits-1:0]    err;
    logic                  last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == 8'h5F);
  endfunction
endpackage
`default_nettype wire

/* hdl/sst_front.sv */
// Scanner front end: per-byte state machine that classifies bytes and forms up
// to three tokens per item. Depends on sst_pkg.
`default_nettype none
module sst_front #(
  parameter int POSITION_BITS = sst_pkg::PositionBitsDefault,
  parameter int LINE_BITS = sst_pkg::LineBitsDefault
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire logic mode,
  input  wire logic [7:0] byte_in,
  output sst_pkg::token_t tok [4],
  output logic [2:0] tok_cnt
);
  import sst_pkg::*;

  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [LINE_BITS-1:0] LineMax = '1;

  scan_state_t st_r, st_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, beg_r, beg_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [KwCount-1:0] cand_r, cand_nxt;
  logic [2:0] wlen_r, wlen_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic halt_r, halt_nxt;

  // Working variables of the combinational pass
  logic [KwCount-1:0] cand_w;
  logic [2:0] wlen_w;
  logic [LINE_BITS-1:0] line_w;
  logic [POSITION_BITS-1:0] dot_w;
  logic [KindBits-1:0] wk;
  logic [KindBits-1:0] pk;
  logic pk_ok;
  logic rescan;
  logic found;

  function automatic logic [OutPosBits-1:0] opos(input logic [POSITION_BITS-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[OutPosBits-1:0];
  endfunction

  function automatic logic [OutLineBits-1:0] oline(input logic [LINE_BITS-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[OutLineBits-1:0];
  endfunction

  function automatic logic [POSITION_BITS-1:0] span(input logic [POSITION_BITS-1:0] f,
                                                     input logic [POSITION_BITS-1:0] t);
    return (t >= f) ? t - f : '0;
  endfunction

  function automatic logic [KindBits-1:0] single_k(input logic [7:0] p);
    case (p)
      8'h2F: return K_SLASH;
      8'h2D: return K_MINUS;
      8'h3D: return K_ASSIGN;
      8'h21: return K_BANG;
      8'h3C: return K_LT;
      default: return K_GT;
    endcase
  endfunction

  function automatic logic [KindBits-1:0] fixed_k(input logic [7:0] b);
    case (b)
      8'h2B: return K_PLUS;
      8'h2A: return K_STAR;
      8'h25: return K_PERCENT;
      8'h28: return K_LPAREN;
      8'h29: return K_RPAREN;
      8'h7B: return K_LBRACE;
      8'h7D: return K_RBRACE;
      8'h5B: return K_LBRACK;
      8'h5D: return K_RBRACK;
      8'h2C: return K_COMMA;
      default: return K_DOT;
    endcase
  endfunction

  always_comb begin
    st_nxt = st_r;
    pos_nxt = pos_r;
    beg_nxt = beg_r;
    line_w = line_r;
    cand_w = cand_r;
    wlen_w = wlen_r;
    pend_nxt = pend_r;
    halt_nxt = halt_r;
    tok_cnt = 3'd0;
    for (int i = 0; i < 4; i++) tok[i] = '0;
    rescan = 1'b0;
    dot_w = (pos_r > beg_r) ? pos_r - 1'b1 : beg_r;
    // word kind from current candidates
    wk = K_IDENT;
    found = 1'b0;
    for (int k = 0; k < KwCount; k++) begin
      if (!found && cand_r[k] && KW_LEN[k] == wlen_r) begin
        wk = KindBits'(k);
        found = 1'b1;
      end
    end
    // pair operator lookup
    pk_ok = 1'b1;
    pk = K_END;
    if (pend_r == 8'h2D && byte_in == 8'h3E) pk = K_ARROW;
    else if (byte_in == 8'h3D && pend_r == 8'h3D) pk = K_EQ;
    else if (byte_in == 8'h3D && pend_r == 8'h21) pk = K_NE;
    else if (byte_in == 8'h3D && pend_r == 8'h3C) pk = K_LE;
    else if (byte_in == 8'h3D && pend_r == 8'h3E) pk = K_GE;
    else if (pend_r == 8'h26 && byte_in == 8'h26) pk = K_AND;
    else if (pend_r == 8'h7C && byte_in == 8'h7C) pk = K_OR;
    else pk_ok = 1'b0;

    if (step) begin
      if (mode) begin
        if (!halt_r) begin
          case (st_r)
            S_PEND: begin
              if (pend_r == 8'h26 || pend_r == 8'h7C) begin
                tok[tok_cnt[1:0]] = '{K_END, opos(beg_r), 20'd1, oline(line_w),
                                      (pend_r == 8'h26) ? E_AMP : E_BAR, 1'b1};
                tok_cnt = tok_cnt + 3'd1;
                halt_nxt = 1'b1;
              end else begin
                tok[tok_cnt[1:0]] = '{single_k(pend_r), opos(beg_r), 20'd1,
                                      oline(line_w), E_NONE, 1'b0};
                tok_cnt = tok_cnt + 3'd1;
              end
            end
            S_INT, S_FRAC: begin
              tok[tok_cnt[1:0]] = '{K_NUMBER, opos(beg_r), opos(span(beg_r, pos_r)),
                                    oline(line_w), E_NONE, 1'b0};
              tok_cnt = tok_cnt + 3'd1;
            end
            S_DOTWAIT: begin
              tok[0] = '{K_NUMBER, opos(beg_r), opos(span(beg_r, dot_w)),
                         oline(line_w), E_NONE, 1'b0};
              tok[1] = '{K_DOT, opos(dot_w), 20'd1, oline(line_w), E_NONE, 1'b0};
              tok_cnt = 3'd2;
            end
            S_STRING: begin
              tok[0] = '{K_END, opos(beg_r), opos(span(beg_r, pos_r)),
                         oline(line_w), E_STRING, 1'b1};
              tok_cnt = 3'd1;
              halt_nxt = 1'b1;
            end
            S_WORD: begin
              tok[0] = '{wk, opos(beg_r), opos(span(beg_r, pos_r)),
                         oline(line_w), E_NONE, 1'b0};
              tok_cnt = 3'd1;
            end
            default: ;
          endcase
          if (!halt_nxt) begin
            tok[tok_cnt[1:0]] = '{K_END, opos(pos_r), 20'd0, oline(line_w),
                                  E_NONE, 1'b1};
            tok_cnt = tok_cnt + 3'd1;
          end
        end
        // back to reset values
        st_nxt = S_IDLE;
        pos_nxt = '0;
        beg_nxt = '0;
        line_w = LINE_BITS'(1);
        cand_w = KW_ALL;
        wlen_w = 3'd0;
        pend_nxt = 8'd0;
        halt_nxt = 1'b0;
      end else if (!halt_r) begin
        case (st_r)
          S_PEND: begin
            if (pend_r == 8'h2F && byte_in == 8'h2F) st_nxt = S_COMMENT;
            else if (pk_ok) begin
              tok[0] = '{pk, opos(beg_r), 20'd2, oline(line_w), E_NONE, 1'b0};
              tok_cnt = 3'd1;
              st_nxt = S_IDLE;
            end else if (pend_r == 8'h26 || pend_r == 8'h7C) begin
              tok[0] = '{K_END, opos(beg_r), 20'd1, oline(line_w),
                         (pend_r == 8'h26) ? E_AMP : E_BAR, 1'b1};
              tok_cnt = 3'd1;
              halt_nxt = 1'b1;
              st_nxt = S_IDLE;
            end else begin
              tok[0] = '{single_k(pend_r), opos(beg_r), 20'd1,
                         oline(line_w), E_NONE, 1'b0};
              tok_cnt = 3'd1;
              rescan = 1'b1;
            end
          end
          S_COMMENT: if (byte_in == 8'h0A) rescan = 1'b1;
          S_INT: begin
            if (byte_in == 8'h2E) st_nxt = S_DOTWAIT;
            else if (!is_digit(byte_in)) begin
              tok[0] = '{K_NUMBER, opos(beg_r), opos(span(beg_r, pos_r)),
                         oline(line_w), E_NONE, 1'b0};
              tok_cnt = 3'd1;
              rescan = 1'b1;
            end
          end
          S_DOTWAIT: begin
            if (is_digit(byte_in)) st_nxt = S_FRAC;
            else begin
              tok[0] = '{K_NUMBER, opos(beg_r), opos(span(beg_r, dot_w)),
                         oline(line_w), E_NONE, 1'b0};
              tok[1] = '{K_DOT, opos(dot_w), 20'd1, oline(line_w), E_NONE, 1'b0};
              tok_cnt = 3'd2;
              rescan = 1'b1;
            end
          end
          S_FRAC: begin
            if (!is_digit(byte_in)) begin
              tok[0] = '{K_NUMBER, opos(beg_r), opos(span(beg_r, pos_r)),
                         oline(line_w), E_NONE, 1'b0};
              tok_cnt = 3'd1;
              rescan = 1'b1;
            end
          end
          S_STRING: begin
            if (byte_in == 8'h22) begin
              tok[0] = '{K_STRING, opos(beg_r), opos(span(beg_r, pos_r)),
                         oline(line_w), E_NONE, 1'b0};
              tok_cnt = 3'd1;
              st_nxt = S_IDLE;
            end else if (byte_in == 8'h0A && line_w != LineMax) begin
              line_w = line_w + 1'b1;
            end
          end
          S_WORD: begin
            if (is_word(byte_in)) begin
              if (wlen_r >= 3'd6) cand_w = '0;
              else
                for (int k = 0; k < KwCount; k++)
                  if (KW_LEN[k] <= wlen_r || KW_TEXT[k][8*wlen_r +: 8] != byte_in)
                    cand_w[k] = 1'b0;
              wlen_w = (wlen_r < 3'd7) ? wlen_r + 3'd1 : 3'd7;
            end else begin
              tok[0] = '{wk, opos(beg_r), opos(span(beg_r, pos_r)),
                         oline(line_w), E_NONE, 1'b0};
              tok_cnt = 3'd1;
              rescan = 1'b1;
            end
          end
          default: rescan = 1'b1;
        endcase

        // Scan the byte from the between-tokens state
        if (rescan) begin
          st_nxt = S_IDLE;
          case (byte_in)
            8'h0A: if (line_w != LineMax) line_w = line_w + 1'b1;
            8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: ;
            8'h2B, 8'h2A, 8'h25, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D,
            8'h2C, 8'h2E: begin
              tok[tok_cnt[1:0]] = '{fixed_k(byte_in), opos(pos_r), 20'd1,
                                    oline(line_w), E_NONE, 1'b0};
              tok_cnt = tok_cnt + 3'd1;
            end
            8'h2F, 8'h2D, 8'h3D, 8'h21, 8'h3C, 8'h3E, 8'h26, 8'h7C: begin
              pend_nxt = byte_in;
              beg_nxt = pos_r;
              st_nxt = S_PEND;
            end
            8'h22: begin
              beg_nxt = (pos_r < PosMax) ? pos_r + 1'b1 : PosMax;
              st_nxt = S_STRING;
            end
            default: begin
              if (is_digit(byte_in)) begin
                beg_nxt = pos_r;
                st_nxt = S_INT;
              end else if (is_alpha(byte_in) || byte_in == 8'h5F) begin
                beg_nxt = pos_r;
                st_nxt = S_WORD;
                for (int k = 0; k < KwCount; k++)
                  cand_w[k] = (KW_TEXT[k][7:0] == byte_in);
                wlen_w = 3'd1;
              end else begin
                tok[tok_cnt[1:0]] = '{K_END, opos(pos_r), 20'd1, oline(line_w),
                                      E_UNKNOWN, 1'b1};
                tok_cnt = tok_cnt + 3'd1;
                halt_nxt = 1'b1;
              end
            end
          endcase
        end
        if (pos_r < PosMax) pos_nxt = pos_r + 1'b1;
      end
    end
    line_nxt = line_w;
    cand_nxt = cand_w;
    wlen_nxt = wlen_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pos_r <= '0;
      beg_r <= '0;
      line_r <= LINE_BITS'(1);
      cand_r <= KW_ALL;
      wlen_r <= 3'd0;
      pend_r <= 8'd0;
      halt_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pos_r <= pos_nxt;
      beg_r <= beg_nxt;
      line_r <= line_nxt;
      cand_r <= cand_nxt;
      wlen_r <= wlen_nxt;
      pend_r <= pend_nxt;
      halt_r <= halt_nxt;
    end
  end
endmodule
`default_nettype wire

/* hdl/sst_queue.sv */
// Token queue between scanner and output port: takes up to four tokens per
// cycle, hands out one while the reader is ready. Depends on sst_pkg.
`default_nettype none
module sst_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sst_pkg::token_t wr_tok [4],
  input  wire logic [2:0] wr_cnt,
  output logic room,
  output logic rd_valid,
  output sst_pkg::token_t rd_tok,
  input  wire logic rd_ready
);
  import sst_pkg::*;

  localparam int Depth = 8;

  token_t mem_r [Depth];
  logic [2:0] wp_r, rp_r;
  logic [3:0] cnt_r, cnt_nxt;
  logic pop;

  assign pop = rd_valid && rd_ready;
  assign rd_valid = (cnt_r != 4'd0);
  assign rd_tok = mem_r[rp_r];
  // room for a full burst of four
  assign room = (cnt_r <= 4'd4);
  assign cnt_nxt = cnt_r + {1'b0, wr_cnt} - {3'd0, pop};

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++)
      if (3'(i) < wr_cnt) mem_r[wp_r + 3'(i)] <= wr_tok[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 3'd0;
      rp_r <= 3'd0;
      cnt_r <= 4'd0;
    end else begin
      wp_r <= wp_r + wr_cnt;
      rp_r <= rp_r + 3'(pop);
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

/* hdl/script_source_tokenizer.sv */
// Top level of the script source tokenizer: scanner front end and token queue.
// Depends on sst_pkg, sst_front and sst_queue.
`default_nettype none
// Takes one source byte (or the end item) per cycle and emits tokens in
// order. A byte is accepted every cycle while the eight-entry token queue has
// room for four tokens; a byte yields at most three tokens and the end item
// at most three, so the queue stalls input whenever it holds more than four
// tokens. The output port shows the queue head directly.
module script_source_tokenizer #(
  parameter int POSITION_BITS = sst_pkg::PositionBitsDefault,
  parameter int LINE_BITS = sst_pkg::LineBitsDefault
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic in_mode,
  input  wire logic [7:0] in_source_byte,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [sst_pkg::KindBits-1:0] out_token_kind,
  output logic [sst_pkg::OutPosBits-1:0] out_token_start,
  output logic [sst_pkg::OutPosBits-1:0] out_token_length,
  output logic [sst_pkg::OutLineBits-1:0] out_token_line,
  output logic [sst_pkg::ErrBits-1:0] out_error_code,
  output logic out_last_of_run
);
  import sst_pkg::*;

  token_t tok [4];
  token_t head;
  logic [2:0] tok_cnt;
  logic room;
  logic step;

  // Transfer a byte when the queue can take a full burst.
  assign in_ready = room;
  assign step = in_valid && room;

  sst_front #(.POSITION_BITS(POSITION_BITS), .LINE_BITS(LINE_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .step(step), .mode(in_mode),
    .byte_in(in_source_byte), .tok(tok), .tok_cnt(tok_cnt)
  );

  sst_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_tok(tok), .wr_cnt(tok_cnt), .room(room),
    .rd_valid(out_valid), .rd_tok(head), .rd_ready(out_ready)
  );

  assign out_token_kind = head.kind;
  assign out_token_start = head.start;
  assign out_token_length = head.len;
  assign out_token_line = head.line;
  assign out_error_code = head.err;
  assign out_last_of_run = head.last;
endmodule
`default_nettype wire

/* tb/sv/tb_script_source_tokenizer.sv */
// Self-checking testbench for script_source_tokenizer: directed source snippets, then random
// token streams, all checked against an in-bench tokenizer model. Depends on sst_pkg and script_source_tokenizer.
`timescale 1ns / 100ps
module tb_script_source_tokenizer;
  import sst_pkg::*;

  localparam int CycleLimit = 600000;
  localparam logic [19:0] PosTop = 20'hFFFFF;
  localparam logic [15:0] LineTop = 16'hFFFF;
  localparam logic ModeByte = 1'b0;
  localparam logic ModeEnd = 1'b1;

  typedef enum logic [2:0] {
    SC_IDLE, SC_PEND, SC_COMMENT, SC_INT, SC_DOTWAIT, SC_FRAC, SC_STRING, SC_WORD
  } lex_state_t;

  // One directed row: an optional raw byte, a text, an optional end item, and
  // optionally the kind and error code of the last token it must produce.
  typedef struct {
    bit          raw_en;
    logic [7:0]  raw;
    string       text;
    bit          close;
    bit          chk;
    logic [5:0]  kind;
    logic [2:0]  err;
  } snippet_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [7:0] in_source_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KindBits-1:0] out_token_kind;
  logic [OutPosBits-1:0] out_token_start;
  logic [OutPosBits-1:0] out_token_length;
  logic [OutLineBits-1:0] out_token_line;
  logic [ErrBits-1:0] out_error_code;
  logic out_last_of_run;

  script_source_tokenizer i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_source_byte,
    .out_valid, .out_ready, .out_token_kind, .out_token_start, .out_token_length,
    .out_token_line, .out_error_code, .out_last_of_run
  );

  always #5 clk = ~clk;

  // Model state of the tokenizer
  lex_state_t  lx_state;
  logic [19:0] lx_pos, lx_begin;
  logic [15:0] lx_line;
  logic [12:0] lx_cand;
  int          lx_wlen;
  logic [7:0]  lx_pend;
  bit          lx_halted;

  token_t token_q[$];
  token_t last_token;
  string  kw_words[13] = '{"fun", "return", "if", "elseif", "else", "while", "for",
                           "break", "skip", "true", "false", "null", "print"};
  int     errors = 0;
  int     cycles = 0;
  int     items = 0;
  bit     calm = 1'b0;
  int     stall_left = 0;

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic void lex_clear();
    lx_state = SC_IDLE;
    lx_pos = '0;
    lx_begin = '0;
    lx_line = 16'd1;
    lx_cand = '1;
    lx_wlen = 0;
    lx_pend = 8'h00;
    lx_halted = 1'b0;
  endfunction

  function automatic void push_token(logic [5:0] kind, logic [19:0] start, logic [19:0] len,
                                     logic [2:0] err, logic last);
    token_t t;
    t.kind = kind;
    t.start = start;
    t.len = len;
    t.line = lx_line;
    t.err = err;
    t.last = last;
    token_q.insert(token_q.size(), t);
    last_token = t;
  endfunction

  function automatic logic [19:0] span(logic [19:0] from, logic [19:0] upto);
    return (upto >= from) ? upto - from : 20'd0;
  endfunction

  function automatic bit digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic void halt_on(logic [2:0] code, logic [19:0] start, logic [19:0] len);
    push_token(K_END, start, len, code, 1'b1);
    lx_halted = 1'b1;
    lx_state = SC_IDLE;
  endfunction

  function automatic void bump_line();
    if (lx_line < LineTop) lx_line++;
  endfunction

  function automatic void word_step(logic [7:0] b);
    if (lx_wlen >= 6) begin
      lx_cand = '0;
    end else begin
      for (int k = 0; k < 13; k++)
        if (kw_words[k].len() <= lx_wlen || kw_words[k][lx_wlen] != b) lx_cand[k] = 1'b0;
    end
    if (lx_wlen < 7) lx_wlen++;
  endfunction

  function automatic logic [5:0] word_kind();
    for (int k = 0; k < 13; k++)
      if (lx_cand[k] && kw_words[k].len() == lx_wlen) return 6'(k);
    return K_IDENT;
  endfunction

  function automatic logic [19:0] dot_at(logic [19:0] p);
    return (p > lx_begin) ? p - 20'd1 : lx_begin;
  endfunction

  // Resolve a held operator with no partner byte.
  function automatic void lone_operator();
    lx_state = SC_IDLE;
    case (lx_pend)
      "/": push_token(K_SLASH, lx_begin, 20'd1, E_NONE, 1'b0);
      "-": push_token(K_MINUS, lx_begin, 20'd1, E_NONE, 1'b0);
      "=": push_token(K_ASSIGN, lx_begin, 20'd1, E_NONE, 1'b0);
      "!": push_token(K_BANG, lx_begin, 20'd1, E_NONE, 1'b0);
      "<": push_token(K_LT, lx_begin, 20'd1, E_NONE, 1'b0);
      ">": push_token(K_GT, lx_begin, 20'd1, E_NONE, 1'b0);
      "&": halt_on(E_AMP, lx_begin, 20'd1);
      "|": halt_on(E_BAR, lx_begin, 20'd1);
      default: ;
    endcase
  endfunction

  function automatic void fresh_byte(logic [7:0] b, logic [19:0] p);
    case (b)
      8'h0A: bump_line();
      8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: ;
      "+": push_token(K_PLUS, p, 20'd1, E_NONE, 1'b0);
      "*": push_token(K_STAR, p, 20'd1, E_NONE, 1'b0);
      "%": push_token(K_PERCENT, p, 20'd1, E_NONE, 1'b0);
      "(": push_token(K_LPAREN, p, 20'd1, E_NONE, 1'b0);
      ")": push_token(K_RPAREN, p, 20'd1, E_NONE, 1'b0);
      "{": push_token(K_LBRACE, p, 20'd1, E_NONE, 1'b0);
      "}": push_token(K_RBRACE, p, 20'd1, E_NONE, 1'b0);
      "[": push_token(K_LBRACK, p, 20'd1, E_NONE, 1'b0);
      "]": push_token(K_RBRACK, p, 20'd1, E_NONE, 1'b0);
      ",": push_token(K_COMMA, p, 20'd1, E_NONE, 1'b0);
      ".": push_token(K_DOT, p, 20'd1, E_NONE, 1'b0);
      "/", "-", "=", "!", "<", ">", "&", "|": begin
        lx_pend = b;
        lx_begin = p;
        lx_state = SC_PEND;
      end
      "\"": begin
        lx_begin = (p < PosTop) ? p + 20'd1 : PosTop;
        lx_state = SC_STRING;
      end
      default: begin
        if (digit(b)) begin
          lx_begin = p;
          lx_state = SC_INT;
        end else if (letter(b) || b == "_") begin
          lx_begin = p;
          lx_state = SC_WORD;
          lx_cand = '1;
          lx_wlen = 0;
          word_step(b);
        end else begin
          halt_on(E_UNKNOWN, p, 20'd1);
        end
      end
    endcase
  endfunction

  function automatic void scan_source_byte(logic [7:0] b, logic [19:0] p);
    logic [19:0] d;
    case (lx_state)
      SC_PEND: begin
        if (lx_pend == "/" && b == "/") begin
          lx_state = SC_COMMENT;
          return;
        end
        if (lx_pend == "-" && b == ">") begin
          push_token(K_ARROW, lx_begin, 20'd2, E_NONE, 1'b0);
          lx_state = SC_IDLE;
          return;
        end
        if (b == "=" && (lx_pend == "=" || lx_pend == "!" || lx_pend == "<" || lx_pend == ">")) begin
          case (lx_pend)
            "=": push_token(K_EQ, lx_begin, 20'd2, E_NONE, 1'b0);
            "!": push_token(K_NE, lx_begin, 20'd2, E_NONE, 1'b0);
            "<": push_token(K_LE, lx_begin, 20'd2, E_NONE, 1'b0);
            default: push_token(K_GE, lx_begin, 20'd2, E_NONE, 1'b0);
          endcase
          lx_state = SC_IDLE;
          return;
        end
        if ((lx_pend == "&" && b == "&") || (lx_pend == "|" && b == "|")) begin
          push_token(lx_pend == "&" ? K_AND : K_OR, lx_begin, 20'd2, E_NONE, 1'b0);
          lx_state = SC_IDLE;
          return;
        end
        lone_operator();
        if (lx_halted) return;
      end
      SC_COMMENT: begin
        if (b != 8'h0A) return;
        lx_state = SC_IDLE;
      end
      SC_INT, SC_FRAC: begin
        if (digit(b)) return;
        if (b == "." && lx_state == SC_INT) begin
          lx_state = SC_DOTWAIT;
          return;
        end
        push_token(K_NUMBER, lx_begin, span(lx_begin, p), E_NONE, 1'b0);
        lx_state = SC_IDLE;
      end
      SC_DOTWAIT: begin
        if (digit(b)) begin
          lx_state = SC_FRAC;
          return;
        end
        d = dot_at(p);
        push_token(K_NUMBER, lx_begin, span(lx_begin, d), E_NONE, 1'b0);
        push_token(K_DOT, d, 20'd1, E_NONE, 1'b0);
        lx_state = SC_IDLE;
      end
      SC_STRING: begin
        if (b == "\"") begin
          push_token(K_STRING, lx_begin, span(lx_begin, p), E_NONE, 1'b0);
          lx_state = SC_IDLE;
        end else if (b == 8'h0A) begin
          bump_line();
        end
        return;
      end
      SC_WORD: begin
        if (letter(b) || digit(b) || b == "_") begin
          word_step(b);
          return;
        end
        push_token(word_kind(), lx_begin, span(lx_begin, p), E_NONE, 1'b0);
        lx_state = SC_IDLE;
      end
      default: lx_state = SC_IDLE;
    endcase
    fresh_byte(b, p);
  endfunction

  // Work out the tokens caused by one accepted transfer.
  function automatic void tokenize_item(logic mode, logic [7:0] b);
    logic [19:0] p, d;
    p = lx_pos;
    if (mode == ModeEnd) begin
      if (!lx_halted) begin
        case (lx_state)
          SC_PEND: lone_operator();
          SC_INT, SC_FRAC: push_token(K_NUMBER, lx_begin, span(lx_begin, p), E_NONE, 1'b0);
          SC_DOTWAIT: begin
            d = dot_at(p);
            push_token(K_NUMBER, lx_begin, span(lx_begin, d), E_NONE, 1'b0);
            push_token(K_DOT, d, 20'd1, E_NONE, 1'b0);
          end
          SC_STRING: halt_on(E_STRING, lx_begin, span(lx_begin, p));
          SC_WORD: push_token(word_kind(), lx_begin, span(lx_begin, p), E_NONE, 1'b0);
          default: ;
        endcase
        if (!lx_halted) push_token(K_END, p, 20'd0, E_NONE, 1'b1);
      end
      lex_clear();
      return;
    end
    if (lx_halted) return;
    scan_source_byte(b, p);
    if (p < PosTop) lx_pos = p + 20'd1;
  endfunction

  // Present one item, hold it until the transfer, then predict.
  task automatic send(logic mode, logic [7:0] b);
    int gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) :
          ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
    if (calm) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_source_byte <= b;
    do @(posedge clk); while (!in_ready);
    tokenize_item(mode, b);
    items++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(ModeByte, s[i]);
  endtask

  // Hold off the sender until every predicted token has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (token_q.size() != 0);
  endtask

  function automatic logic [7:0] word_char(bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  // One random source fragment; mostly well-formed, sometimes noise.
  task automatic random_fragment();
    string ops[20] = '{"+", "*", "%", "(", ")", "{", "}", "[", "]", ",", ".", "-", "->",
                       "=", "==", "!", "!=", "<=", ">=", "&&"};
    string tails[6] = '{"||", "<", ">", "/", "&", "|"};
    int n;
    case ($urandom_range(0, 15))
      0, 1: send_text(kw_words[$urandom_range(0, 12)]);
      2, 3: begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 11) : $urandom_range(1, 5);
        send(ModeByte, word_char(1'b1));
        repeat (n - 1) send(ModeByte, word_char(1'b0));
      end
      4, 5: begin
        repeat ($urandom_range(1, 4)) send(ModeByte, 8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          send(ModeByte, ".");
          repeat ($urandom_range(0, 2)) send(ModeByte, 8'("0" + $urandom_range(0, 9)));
        end
      end
      6: begin
        send(ModeByte, "\"");
        repeat ($urandom_range(0, 6))
          send(ModeByte, $urandom_range(0, 5) == 0 ? 8'h0A : 8'($urandom_range(32, 126)) & 8'hFD);
        if ($urandom_range(0, 7) != 0) send(ModeByte, "\"");
      end
      7, 8, 9: send_text(ops[$urandom_range(0, 19)]);
      10: send_text(tails[$urandom_range(0, 5)]);
      11: begin
        send_text("//");
        repeat ($urandom_range(0, 5)) send(ModeByte, 8'($urandom_range(0, 255)) | 8'h10);
        send(ModeByte, 8'h0A);
      end
      12, 13: begin
        case ($urandom_range(0, 5))
          0: send(ModeByte, 8'h09);
          1: send(ModeByte, 8'h0A);
          2: send(ModeByte, 8'h0B);
          3: send(ModeByte, 8'h0C);
          4: send(ModeByte, 8'h0D);
          default: send(ModeByte, 8'h20);
        endcase
      end
      14: send(ModeByte, 8'h20);
      default: begin
        // noise: any byte at all, often an error
        if ($urandom_range(0, 3) == 0) send(ModeByte, 8'($urandom_range(0, 255)));
        else send(ModeByte, 8'h20);
      end
    endcase
  endtask

  // Receiver: short stalls now and then, a few long ones, none while calm.
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every output transfer with the oldest predicted token.
  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        report("unexpected token kind", out_token_kind, -1);
      end else begin
        want = token_q.pop_front();
        if (out_token_kind !== want.kind) report("token_kind", out_token_kind, want.kind);
        if (out_token_start !== want.start) report("token_start", out_token_start, want.start);
        if (out_token_length !== want.len) report("token_length", out_token_length, want.len);
        if (out_token_line !== want.line) report("token_line", out_token_line, want.line);
        if (out_error_code !== want.err) report("error_code", out_error_code, want.err);
        if (out_last_of_run !== want.last) report("last_of_run", out_last_of_run, want.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("script_source_tokenizer test failed");
      $finish;
    end
  end

  initial begin
    snippet_t rows[15];
    rows = '{
      '{0, 8'h00, "fun return if elseif else while for break skip true false null print",
        1, 1, K_END, E_NONE},
      '{0, 8'h00, "abc_12 _x longidentifier printx iff 0 9 12.5 7. 3.x", 1, 1, K_END, E_NONE},
      '{0, 8'h00, "+*%/(){}[],.-", 1, 1, K_END, E_NONE},
      '{0, 8'h00, "-> = == ! != < <= > >= && || a-", 1, 1, K_END, E_NONE},
      '{0, 8'h00, "a//note\nb /", 1, 1, K_END, E_NONE},
      '{0, 8'h00, "\"str\nline\" \"\" 7..8 1.2.3", 1, 0, K_END, E_NONE},
      '{0, 8'h00, "@", 1, 1, K_END, E_UNKNOWN},
      '{0, 8'h00, "&x", 1, 1, K_END, E_AMP},
      '{0, 8'h00, "|", 1, 1, K_END, E_BAR},
      '{0, 8'h00, "\"open", 1, 1, K_END, E_STRING},
      '{1, 8'h0D, "\t\n 5", 1, 1, K_END, E_NONE},
      '{1, 8'h00, "", 0, 1, K_END, E_UNKNOWN},
      '{0, 8'h00, " x", 1, 0, K_END, E_NONE},
      '{1, 8'hFF, "", 1, 1, K_END, E_UNKNOWN},
      '{0, 8'h00, "a=!b<-c>d 42.", 1, 1, K_END, E_NONE}
    };
    lex_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed snippets; most carry the kind and error code of the token that must close them.
    foreach (rows[i]) begin
      if (rows[i].raw_en) send(ModeByte, rows[i].raw);
      send_text(rows[i].text);
      if (rows[i].close) send(ModeEnd, 8'h00);
      if (rows[i].chk && (last_token.kind !== rows[i].kind || last_token.err !== rows[i].err))
        report("directed row closing error code", last_token.err, rows[i].err);
    end
    drain();

    // Random token streams; a calm stretch with no idling on either side.
    while (items < 430) begin
      calm = (items > 200 && items < 260);
      random_fragment();
      if ($urandom_range(0, 24) == 0) send(ModeEnd, 8'($urandom_range(0, 255)));
    end
    calm = 1'b0;
    send(ModeEnd, 8'h00);
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("script_source_tokenizer test passed");
    end else begin
      $display("script_source_tokenizer test failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
hdl/sst_pkg.sv
hdl/sst_front.sv
hdl/sst_queue.sv
hdl/script_source_tokenizer.sv
tb/sv/tb_script_source_tokenizer.sv
